[sv/y4m_pkg.sv]
// Shared types and constants for the YUV4MPEG2 header line parser.
// No dependencies; imported by every module of the block.
package y4m_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_LINE    = 3'd1;
  localparam logic [2:0] ST_BAD_SCAN   = 3'd2;
  localparam logic [2:0] ST_BAD_CHROMA = 3'd3;
  localparam logic [2:0] ST_NO_WIDTH   = 3'd4;
  localparam logic [2:0] ST_NO_HEIGHT  = 3'd5;
  localparam logic [2:0] ST_NO_RATE    = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_T_LO  = 8'h74;

  // Field widths
  localparam int DIV_W     = 32;
  localparam int NAME_CHARS = 8;
  localparam int NUM_NAMES = 27;

  localparam logic [4:0] DEPTH_DEFAULT = 5'd8;

  typedef struct packed {
    logic [63:0] name;   // left aligned, zero padded
    logic [3:0]  len;
    logic [2:0]  layout;
    logic [4:0]  depth;
  } chroma_ent_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] layout;
    logic [4:0] depth;
  } chroma_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam chroma_ent_t CHROMA_TAB [NUM_NAMES] = '{
    '{"420mpeg2",              4'd8, 3'd0, 5'd8},
    '{"420paldv",              4'd8, 3'd0, 5'd8},
    '{{"420jpeg", 8'h00},      4'd7, 3'd0, 5'd8},
    '{{"420p16", 16'h0},       4'd6, 3'd0, 5'd16},
    '{{"422p16", 16'h0},       4'd6, 3'd2, 5'd16},
    '{{"444p16", 16'h0},       4'd6, 3'd3, 5'd16},
    '{{"420p14", 16'h0},       4'd6, 3'd0, 5'd14},
    '{{"422p14", 16'h0},       4'd6, 3'd2, 5'd14},
    '{{"444p14", 16'h0},       4'd6, 3'd3, 5'd14},
    '{{"420p12", 16'h0},       4'd6, 3'd0, 5'd12},
    '{{"422p12", 16'h0},       4'd6, 3'd2, 5'd12},
    '{{"444p12", 16'h0},       4'd6, 3'd3, 5'd12},
    '{{"420p10", 16'h0},       4'd6, 3'd0, 5'd10},
    '{{"422p10", 16'h0},       4'd6, 3'd2, 5'd10},
    '{{"444p10", 16'h0},       4'd6, 3'd3, 5'd10},
    '{{"420p9", 24'h0},        4'd5, 3'd0, 5'd9},
    '{{"422p9", 24'h0},        4'd5, 3'd2, 5'd9},
    '{{"444p9", 24'h0},        4'd5, 3'd3, 5'd9},
    '{{"420", 40'h0},          4'd3, 3'd0, 5'd8},
    '{{"411", 40'h0},          4'd3, 3'd1, 5'd8},
    '{{"422", 40'h0},          4'd3, 3'd2, 5'd8},
    '{{"444", 40'h0},          4'd3, 3'd3, 5'd8},
    '{{"mono16", 16'h0},       4'd6, 3'd4, 5'd16},
    '{{"mono12", 16'h0},       4'd6, 3'd4, 5'd12},
    '{{"mono10", 16'h0},       4'd6, 3'd4, 5'd10},
    '{{"mono9", 24'h0},        4'd5, 3'd4, 5'd9},
    '{{"mono", 32'h0},         4'd4, 3'd4, 5'd8}
  };

endpackage

[sv/y4m_header_line_parser_unit.sv]
// YUV4MPEG2 header line parser: one header byte per request.
// An ordinary byte updates the parse state. A line end registers its result on
// error, else once the quotient of the bit-serial rate divider is stored.
// Input is held off while the divider runs and for the cycle that stores its
// quotient, and a line end waits for a free output register.
// Reset (rst, synchronous) returns to an empty line.
module y4m_header_line_parser_unit #(
  parameter int MAX_LINE    = 80,
  parameter int TOKEN_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] frame_width,
  output logic [15:0] frame_height,
  output logic [31:0] rate_numerator,
  output logic [31:0] rate_denominator,
  output logic [31:0] rate_whole,
  output logic [4:0]  sample_depth,
  output logic [2:0]  chroma_layout,
  output logic [1:0]  scan_order
);
  import y4m_pkg::*;

  localparam int LCW = $clog2(MAX_LINE);
  localparam logic [LCW-1:0] LINE_LIM = LCW'(MAX_LINE - 1);

  localparam logic [3:0] PH_GAP  = 4'd0;
  localparam logic [3:0] PH_WID  = 4'd1;
  localparam logic [3:0] PH_HGT  = 4'd2;
  localparam logic [3:0] PH_SCAN = 4'd3;
  localparam logic [3:0] PH_CHR  = 4'd4;
  localparam logic [3:0] PH_RNUM = 4'd5;
  localparam logic [3:0] PH_RDEN = 4'd6;
  localparam logic [3:0] PH_ANUM = 4'd7;
  localparam logic [3:0] PH_ADEN = 4'd8;
  localparam logic [3:0] PH_SKIP = 4'd9;
  localparam logic [3:0] PH_STOP = 4'd10;

  logic [3:0]     phase, phase_next;
  logic [31:0]    acc, acc_next;
  logic           open, open_next;
  logic [15:0]    width, width_next;
  logic [15:0]    height, height_next;
  logic [31:0]    num, num_next;
  logic [31:0]    den, den_next;
  logic [4:0]     depth, depth_next;
  logic [2:0]     layout, layout_next;
  logic [1:0]     scan, scan_next;
  logic [2:0]     err, err_next;
  logic [LCW-1:0] line_count, line_count_next;

  logic [15:0] fin_width, fin_height;
  logic [31:0] fin_num, fin_den;
  logic [4:0]  fin_depth;
  logic [2:0]  fin_layout, fin_err, fin_status;

  logic        in_fire, ends, end_fire, byte_fire, is_digit;
  logic [35:0] mac_wide;
  logic [31:0] mac, acc_word;
  logic [15:0] acc_sat16;
  logic        tok_clear, tok_push;
  logic [3:0]  disp_phase;
  logic        disp_num, disp_tok;

  chroma_res_t chr;
  div_stat_t   dstat;
  logic        div_start;
  logic [31:0] quotient;

  y4m_chroma #(.TOKEN_CHARS(TOKEN_CHARS)) u_chroma (
    .clk       (clk),
    .rst       (rst),
    .clear     (tok_clear),
    .push      (tok_push),
    .data_byte (data_byte),
    .res       (chr)
  );

  y4m_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (fin_num),
    .divisor  (fin_den),
    .stat     (dstat),
    .quotient (quotient)
  );

  // Handshake: held off by the divider; a line end needs the output register free
  assign ends      = end_of_stream || (data_byte == CH_LF);
  assign in_ready  = !dstat.busy && !dstat.done && (!out_valid || out_ready || !ends);
  assign in_fire   = in_valid && in_ready;
  assign end_fire  = in_fire && ends;
  assign byte_fire = in_fire && !ends && (line_count < LINE_LIM);

  // Decimal accumulate, saturating at 32 bits
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign acc_word  = acc;
  assign mac_wide  = {1'b0, acc_word, 3'b000} + {3'b000, acc_word, 1'b0}
                   + {28'd0, data_byte - CH_ZERO};
  assign mac       = (mac_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : mac_wide[31:0];
  assign acc_sat16 = (acc[31:16] != 16'd0) ? 16'hFFFF : acc[15:0];

  // Close the open token as a line end or zero byte would
  always_comb begin
    fin_width  = width;
    fin_height = height;
    fin_num    = num;
    fin_den    = den;
    fin_depth  = depth;
    fin_layout = layout;
    fin_err    = err;
    priority case (phase)
      PH_WID:  fin_width  = acc_sat16;
      PH_HGT:  fin_height = acc_sat16;
      PH_SCAN: fin_err    = (err == ST_OK) ? ST_BAD_SCAN : err;
      PH_CHR: begin
        if (chr.hit) begin
          fin_layout = chr.layout;
          fin_depth  = chr.depth;
        end else begin
          fin_err = (err == ST_OK) ? ST_BAD_CHROMA : err;
        end
      end
      PH_RNUM: begin
        fin_num = acc;
        fin_den = 32'd0;
      end
      PH_RDEN: fin_den = acc;
      default: ;
    endcase
  end

  // Line status, first error wins
  always_comb begin
    if (end_of_stream && (line_count == '0)) begin
      fin_status = ST_NO_LINE;
    end else if (fin_err != ST_OK) begin
      fin_status = fin_err;
    end else if (fin_width == 16'd0) begin
      fin_status = ST_NO_WIDTH;
    end else if (fin_height == 16'd0) begin
      fin_status = ST_NO_HEIGHT;
    end else if ((fin_num == 32'd0) || (fin_den == 32'd0)) begin
      fin_status = ST_NO_RATE;
    end else begin
      fin_status = ST_OK;
    end
  end

  // Token key decode
  always_comb begin
    disp_num = 1'b0;
    disp_tok = 1'b0;
    unique case (data_byte)
      CH_SPACE: disp_phase = PH_GAP;
      CH_W: begin
        disp_phase = PH_WID;
        disp_num   = 1'b1;
      end
      CH_H: begin
        disp_phase = PH_HGT;
        disp_num   = 1'b1;
      end
      CH_F: begin
        disp_phase = PH_RNUM;
        disp_num   = 1'b1;
      end
      CH_A: disp_phase = PH_ANUM;
      CH_I: disp_phase = PH_SCAN;
      CH_C: begin
        disp_phase = PH_CHR;
        disp_tok   = 1'b1;
      end
      default: disp_phase = PH_SKIP;
    endcase
  end

  // Per-byte parse step
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    open_next       = open;
    width_next      = width;
    height_next     = height;
    num_next        = num;
    den_next        = den;
    depth_next      = depth;
    layout_next     = layout;
    scan_next       = scan;
    err_next        = err;
    line_count_next = line_count;
    tok_clear       = 1'b0;
    tok_push        = 1'b0;

    if (end_fire) begin
      phase_next      = PH_GAP;
      acc_next        = 32'd0;
      open_next       = 1'b1;
      width_next      = 16'd0;
      height_next     = 16'd0;
      num_next        = 32'd0;
      den_next        = 32'd0;
      depth_next      = DEPTH_DEFAULT;
      layout_next     = 3'd0;
      scan_next       = 2'd0;
      err_next        = ST_OK;
      line_count_next = '0;
      tok_clear       = 1'b1;
    end else if (byte_fire) begin
      line_count_next = line_count + 1'b1;
      if (phase != PH_STOP) begin
        if (data_byte == CH_NUL) begin
          width_next  = fin_width;
          height_next = fin_height;
          num_next    = fin_num;
          den_next    = fin_den;
          depth_next  = fin_depth;
          layout_next = fin_layout;
          err_next    = fin_err;
          phase_next  = PH_STOP;
        end else begin
          priority case (phase)
            PH_GAP, PH_WID, PH_HGT: begin
              if ((phase != PH_GAP) && is_digit) begin
                if (open) acc_next = mac;
              end else begin
                if (phase == PH_WID) width_next = acc_sat16;
                if (phase == PH_HGT) height_next = acc_sat16;
                phase_next = disp_phase;
                if (disp_num) begin
                  acc_next  = 32'd0;
                  open_next = 1'b1;
                end
                tok_clear = disp_tok;
              end
            end
            PH_SCAN: begin
              phase_next = PH_GAP;
              if (data_byte == CH_P_LO) begin
                scan_next = 2'd0;
              end else if (data_byte == CH_T_LO) begin
                scan_next = 2'd1;
              end else if (data_byte == CH_B_LO) begin
                scan_next = 2'd2;
              end else begin
                err_next   = fin_err;
                phase_next = PH_STOP;
              end
            end
            PH_CHR: begin
              if (data_byte == CH_SPACE) begin
                depth_next  = fin_depth;
                layout_next = fin_layout;
                err_next    = fin_err;
                phase_next  = chr.hit ? PH_GAP : PH_STOP;
              end else begin
                tok_push = 1'b1;
              end
            end
            PH_RNUM, PH_RDEN: begin
              if ((phase == PH_RNUM) && (data_byte == CH_COLON)) begin
                num_next   = acc;
                phase_next = PH_RDEN;
                acc_next   = 32'd0;
                open_next  = 1'b1;
              end else if ((phase == PH_RDEN) && (data_byte == CH_SPACE)) begin
                den_next   = acc;
                phase_next = PH_GAP;
              end else if (open && is_digit) begin
                acc_next = mac;
              end else begin
                open_next = 1'b0;
              end
            end
            PH_ANUM: begin
              if (data_byte == CH_COLON) phase_next = PH_ADEN;
            end
            PH_ADEN, PH_SKIP: begin
              if (data_byte == CH_SPACE) phase_next = PH_GAP;
            end
            default: phase_next = PH_STOP;
          endcase
        end
      end
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_GAP;
      acc        <= 32'd0;
      open       <= 1'b1;
      width      <= 16'd0;
      height     <= 16'd0;
      num        <= 32'd0;
      den        <= 32'd0;
      depth      <= DEPTH_DEFAULT;
      layout     <= 3'd0;
      scan       <= 2'd0;
      err        <= ST_OK;
      line_count <= '0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      open       <= open_next;
      width      <= width_next;
      height     <= height_next;
      num        <= num_next;
      den        <= den_next;
      depth      <= depth_next;
      layout     <= layout_next;
      scan       <= scan_next;
      err        <= err_next;
      line_count <= line_count_next;
    end
  end

  // Start the divider only for a good line
  assign div_start = end_fire && (fin_status == ST_OK);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_fire) begin
      out_valid <= (fin_status != ST_OK);
    end else if (dstat.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) begin
      status           <= fin_status;
      frame_width      <= fin_width;
      frame_height     <= fin_height;
      rate_numerator   <= fin_num;
      rate_denominator <= fin_den;
      rate_whole       <= 32'd0;
      sample_depth     <= fin_depth;
      chroma_layout    <= fin_layout;
      scan_order       <= scan;
    end else if (dstat.done) begin
      rate_whole <= quotient;
    end
  end

endmodule

[sv/y4m_chroma.sv]
// Chroma token store and name matcher for the header line parser.
// Depends on y4m_pkg for the name table and result struct.
module y4m_chroma #(
  parameter int TOKEN_CHARS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  push,
  input  logic [7:0]            data_byte,
  output y4m_pkg::chroma_res_t  res
);
  import y4m_pkg::*;

  localparam int IW = $clog2(TOKEN_CHARS);
  localparam int LW = $clog2(TOKEN_CHARS + 2);

  logic [7:0]    store [TOKEN_CHARS];
  logic [LW-1:0] len;
  logic [63:0]   word;

  // Hold the name bytes; extra bytes only count towards the length
  always_ff @(posedge clk) begin
    if (push && (len < LW'(TOKEN_CHARS))) begin
      store[len[IW-1:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      len <= '0;
    end else if (push && (len <= LW'(TOKEN_CHARS))) begin
      len <= len + 1'b1;
    end
  end

  // Pack the first name characters, first byte on top
  always_comb begin
    for (int i = 0; i < NAME_CHARS; i++) begin
      word[63-8*i -: 8] = store[i];
    end
  end

  // Compare against every known name at once
  always_comb begin
    logic [63:0] mask;
    res = '{hit: 1'b0, layout: 3'd0, depth: DEPTH_DEFAULT};
    for (int k = 0; k < NUM_NAMES; k++) begin
      mask = ~({64{1'b1}} >> (8 * int'(CHROMA_TAB[k].len)));
      if ((len == LW'(CHROMA_TAB[k].len)) && ((word & mask) == CHROMA_TAB[k].name)) begin
        res.hit    = 1'b1;
        res.layout = CHROMA_TAB[k].layout;
        res.depth  = CHROMA_TAB[k].depth;
      end
    end
  end

endmodule

[sv/y4m_div.sv]
// Restoring divider, one quotient bit per cycle, for the frame rate.
// Depends on y4m_pkg for the operand width and status struct.
module y4m_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [y4m_pkg::DIV_W-1:0]     dividend,
  input  logic [y4m_pkg::DIV_W-1:0]     divisor,
  output y4m_pkg::div_stat_t            stat,
  output logic [y4m_pkg::DIV_W-1:0]     quotient
);
  import y4m_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem, quotient[DIV_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient register doubles as the dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
      quotient <= {quotient[DIV_W-2:0], ge};
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

[sv/y4m_checker.sv]
// Port-level checks for the header line parser, bound to the top level.
// Depends on y4m_pkg for status codes.
module y4m_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] frame_width,
  input logic [15:0] frame_height,
  input logic [31:0] rate_denominator,
  input logic [31:0] rate_whole,
  input logic [4:0]  sample_depth
);
  import y4m_pkg::*;

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_err_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> rate_whole == 32'd0)
    else $error("whole rate nonzero on error");

  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |->
      (frame_width != 16'd0) && (frame_height != 16'd0) && (rate_denominator != 32'd0))
    else $error("good status with missing field");

  a_no_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_LINE) |-> (sample_depth == 5'd8) && (frame_width == 16'd0))
    else $error("empty stream result not default");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind y4m_header_line_parser_unit y4m_port_checker u_y4m_port_checker (.*);

[test/y4m_checker.sv]
`timescale 1ns / 1ps
// Checker for the YUV4MPEG2 header line parser: watches both request channels,
// predicts each header result and compares it field by field. Depends on y4m_pkg.
module y4m_checker
  import y4m_pkg::*;
#(
  parameter int MAX_LINE    = 80,
  parameter int TOKEN_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [15:0] frame_width,
  input  logic [15:0] frame_height,
  input  logic [31:0] rate_numerator,
  input  logic [31:0] rate_denominator,
  input  logic [31:0] rate_whole,
  input  logic [4:0]  sample_depth,
  input  logic [2:0]  chroma_layout,
  input  logic [1:0]  scan_order,
  output int          fail_count,
  output int          pending,
  output int          header_count,
  output int          ok_count
);

  typedef enum logic [3:0] {
    P_GAP, P_WID, P_HGT, P_SCAN, P_CHR, P_RNUM, P_RDEN, P_ANUM, P_ADEN, P_SKIP, P_STOP
  } phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] whole;
    logic [4:0]  depth;
    logic [2:0]  layout;
    logic [1:0]  scan;
  } header_t;

  header_t     header_q[$];
  phase_t      ph;
  logic [31:0] accum;
  logic [7:0]  tok [TOKEN_CHARS];
  int          tok_len;
  logic [15:0] wd_r, ht_r;
  logic [31:0] num_r, den_r;
  logic [4:0]  depth_r;
  logic [2:0]  layout_r, err_r;
  logic [1:0]  scan_r;
  int          line_len;
  logic        digits_open;

  function automatic logic [15:0] sat16(logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Return the parser to an empty line
  task automatic clear_line();
    ph = P_GAP; accum = '0; tok_len = 0;
    foreach (tok[i]) tok[i] = '0;
    wd_r = '0; ht_r = '0; num_r = '0; den_r = '0;
    depth_r = DEPTH_DEFAULT; layout_r = '0; scan_r = '0; err_r = ST_OK;
    line_len = 0; digits_open = 1'b1;
  endtask

  task automatic raise(logic [2:0] code);
    if (err_r == ST_OK) err_r = code;
    ph = P_STOP;
  endtask

  task automatic add_digit(logic [7:0] b);
    logic [63:0] v;
    if (digits_open && is_digit(b)) begin
      v = 64'(accum) * 10 + 64'(b - CH_ZERO);
      accum = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    end else begin
      digits_open = 1'b0;
    end
  endtask

  // Look the chroma name up in the table of known layouts
  task automatic judge_chroma();
    logic hit;
    if (tok_len <= TOKEN_CHARS) begin
      foreach (CHROMA_TAB[n]) begin
        hit = (tok_len == CHROMA_TAB[n].len);
        for (int i = 0; i < tok_len && i < NAME_CHARS; i++)
          if (tok[i] != CHROMA_TAB[n].name[63-8*i -: 8]) hit = 1'b0;
        if (hit) begin
          layout_r = CHROMA_TAB[n].layout;
          depth_r  = CHROMA_TAB[n].depth;
          ph = P_GAP;
          return;
        end
      end
    end
    raise(ST_BAD_CHROMA);
  endtask

  task automatic start_number(phase_t p);
    ph = p; accum = '0; digits_open = 1'b1;
  endtask

  task automatic dispatch(logic [7:0] b);
    if (b == CH_SPACE) return;
    case (b)
      CH_W: start_number(P_WID);
      CH_H: start_number(P_HGT);
      CH_F: start_number(P_RNUM);
      CH_A: ph = P_ANUM;
      CH_I: ph = P_SCAN;
      CH_C: begin
        ph = P_CHR; tok_len = 0;
      end
      default: ph = P_SKIP;
    endcase
  endtask

  task automatic close_token();
    case (ph)
      P_WID:  wd_r = sat16(accum);
      P_HGT:  ht_r = sat16(accum);
      P_SCAN: raise(ST_BAD_SCAN);
      P_CHR:  judge_chroma();
      P_RNUM: begin
        num_r = accum; den_r = '0;
      end
      P_RDEN: den_r = accum;
      default: ;
    endcase
    ph = P_STOP;
  endtask

  task automatic parse_byte(logic [7:0] b);
    if (ph == P_STOP) return;
    if (b == CH_NUL) begin
      close_token();
      return;
    end
    case (ph)
      P_GAP: dispatch(b);
      P_WID, P_HGT: begin
        if (is_digit(b)) add_digit(b);
        else begin
          if (ph == P_WID) wd_r = sat16(accum);
          else ht_r = sat16(accum);
          ph = P_GAP;
          dispatch(b);
        end
      end
      P_SCAN: begin
        if (b == CH_P_LO) begin
          scan_r = 2'd0; ph = P_GAP;
        end else if (b == CH_T_LO) begin
          scan_r = 2'd1; ph = P_GAP;
        end else if (b == CH_B_LO) begin
          scan_r = 2'd2; ph = P_GAP;
        end else raise(ST_BAD_SCAN);
      end
      P_CHR: begin
        if (b == CH_SPACE) judge_chroma();
        else begin
          if (tok_len < TOKEN_CHARS) tok[tok_len] = b;
          if (tok_len <= TOKEN_CHARS) tok_len++;
        end
      end
      P_RNUM: begin
        if (b == CH_COLON) begin
          num_r = accum; start_number(P_RDEN);
        end else add_digit(b);
      end
      P_RDEN: begin
        if (b == CH_SPACE) begin
          den_r = accum; ph = P_GAP;
        end else add_digit(b);
      end
      P_ANUM: if (b == CH_COLON) ph = P_ADEN;
      P_ADEN, P_SKIP: if (b == CH_SPACE) ph = P_GAP;
      default: ph = P_STOP;
    endcase
  endtask

  task automatic emit(logic [2:0] st);
    header_t h;
    h.status = st; h.width = wd_r; h.height = ht_r; h.num = num_r; h.den = den_r;
    h.whole  = (st == ST_OK && den_r != 0) ? num_r / den_r : '0;
    h.depth  = depth_r; h.layout = layout_r; h.scan = scan_r;
    header_q.push_back(h);
  endtask

  function automatic logic [2:0] line_status();
    if (err_r != ST_OK) return err_r;
    if (wd_r == 0) return ST_NO_WIDTH;
    if (ht_r == 0) return ST_NO_HEIGHT;
    if (num_r == 0 || den_r == 0) return ST_NO_RATE;
    return ST_OK;
  endfunction

  task automatic end_line();
    if (ph != P_STOP) close_token();
    emit(line_status());
    clear_line();
  endtask

  task automatic field_chk(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0; header_count = 0; ok_count = 0;
    clear_line();
  end

  assign pending = header_q.size();

  // Predict on each accepted byte request, compare on each accepted result
  always @(posedge clk) begin
    header_t h;
    if (rst) begin
      header_q.delete();
      clear_line();
    end else begin
      if (in_valid && in_ready) begin
        if (end_of_stream) begin
          if (line_len == 0) begin
            clear_line();
            emit(ST_NO_LINE);
          end else end_line();
        end else if (data_byte == CH_LF) end_line();
        else if (line_len < MAX_LINE - 1) begin
          line_len++;
          parse_byte(data_byte);
        end
      end
      if (out_valid && out_ready) begin
        header_count++;
        if (header_q.size() == 0) begin
          $error("result with no header line pending");
          fail_count++;
        end else begin
          h = header_q.pop_front();
          if (h.status == ST_OK) ok_count++;
          field_chk("status", 32'(h.status), 32'(status));
          field_chk("frame_width", 32'(h.width), 32'(frame_width));
          field_chk("frame_height", 32'(h.height), 32'(frame_height));
          field_chk("rate_numerator", h.num, rate_numerator);
          field_chk("rate_denominator", h.den, rate_denominator);
          field_chk("rate_whole", h.whole, rate_whole);
          field_chk("sample_depth", 32'(h.depth), 32'(sample_depth));
          field_chk("chroma_layout", 32'(h.layout), 32'(chroma_layout));
          field_chk("scan_order", 32'(h.scan), 32'(scan_order));
        end
      end
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Top of the header parser testbench: drives header lines into the block,
// paces the result side and gives the verdict. Depends on y4m_pkg and y4m_checker.
module tb_top;
  import y4m_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] frame_width, frame_height;
  logic [31:0] rate_numerator, rate_denominator, rate_whole;
  logic [4:0]  sample_depth;
  logic [2:0]  chroma_layout;
  logic [1:0]  scan_order;
  int          fail_count, pending, header_count, ok_count;
  int          bytes_sent = 0;
  logic        quiet_line = 1'b0;
  logic [7:0]  line_q[$];

  string chroma_pool[] = '{"420mpeg2", "420paldv", "420jpeg", "420p16", "422p16",
    "444p16", "420p14", "422p14", "444p14", "420p12", "422p12", "444p12", "420p10",
    "422p10", "444p10", "420p9", "422p9", "444p9", "420", "411", "422", "444",
    "mono16", "mono12", "mono10", "mono9", "mono", "mono8", "420mpeg22", "44", "yuv"};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  y4m_header_line_parser_unit u_dut (.*);

  y4m_checker u_chk (.*);

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte request and hold it until accepted
  task automatic send(logic [7:0] b, logic eos);
    int gap;
    gap = quiet_line ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(logic eos_end);
    foreach (line_q[i]) send(line_q[i], 1'b0);
    send(eos_end ? 8'($urandom_range(0, 255)) : CH_LF, eos_end);
    line_q.delete();
    in_valid <= 1'b0;
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // Decimal digits: usually short, sometimes long enough to saturate
  task automatic push_num();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_token(int kind);
    case (kind)
      0: begin
        line_q.push_back(CH_W); push_num();
      end
      1: begin
        line_q.push_back(CH_H); push_num();
      end
      2: begin
        line_q.push_back(CH_F); push_num();
        if ($urandom_range(0, 9) != 0) line_q.push_back(CH_COLON);
        push_num();
      end
      3: begin
        line_q.push_back(CH_I);
        case ($urandom_range(0, 4))
          0: line_q.push_back(CH_P_LO);
          1: line_q.push_back(CH_T_LO);
          2: line_q.push_back(CH_B_LO);
          default: if ($urandom_range(0, 1)) line_q.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      4: begin
        line_q.push_back(CH_C);
        push_str(chroma_pool[$urandom_range(0, chroma_pool.size() - 1)]);
      end
      5: begin
        line_q.push_back(CH_A); push_num(); line_q.push_back(CH_COLON); push_num();
      end
      6: push_str("XYSCALE=1");
      default: line_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Build a random header line, mostly well formed with random content
  task automatic make_line();
    int n;
    if ($urandom_range(0, 4) != 0) begin
      push_token(0); line_q.push_back(CH_SPACE);
      push_token(1); line_q.push_back(CH_SPACE);
      push_token(2);
      n = $urandom_range(0, 3);
    end else n = $urandom_range(1, 8);
    repeat (n) begin
      line_q.push_back(CH_SPACE);
      push_token(($urandom_range(0, 7) == 0) ? 7 : $urandom_range(0, 6));
    end
    // overlong line: padding may run past the line limit
    if ($urandom_range(0, 24) == 0)
      repeat ($urandom_range(60, 90)) line_q.push_back(CH_SPACE);
  endtask

  // Result side: random stalls, one long hold-off while requests keep coming
  initial begin
    int cyc, hold;
    cyc = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 1500) hold = 400;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (cyc % 700 < 150) out_ready <= 1'b1;
      else out_ready <= (pick_gap() == 0);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines: extremes, saturation, every token and error kind
    send(8'h00, 1'b1);
    push_str("W65536 H1 F4294967296:1 It C444p10 A1:1 "); send_line(1'b0);
    send_line(1'b0);
    push_str("W1 H2 F3"); send_line(1'b0);
    push_str("W7 Ix"); send_line(1'b0);
    line_q.push_back(CH_W); line_q.push_back(CH_ZERO + 8'd1); line_q.push_back(CH_NUL);
    push_str(" junk"); send_line(1'b0);
    push_str("W9 H9 F1:0 C"); send_line(1'b1);
    push_str("Cmono Ib"); send_line(1'b0);

    // Random lines, some in bursts with no gaps
    while (bytes_sent < 1800) begin
      quiet_line = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) send(8'h00, 1'b1);
      else begin
        make_line();
        send_line($urandom_range(0, 19) == 0);
      end
    end
    quiet_line = 1'b0;

    wait (pending == 0);
    repeat (40) @(negedge clk);
    $display("%0d header bytes and line ends sent, %0d results checked (%0d ok)",
             bytes_sent, header_count, ok_count);
    if (fail_count == 0) $display("y4m_header_line_parser_unit regression: pass");
    else $display("y4m_header_line_parser_unit regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("y4m_header_line_parser_unit regression: fail");
    $finish;
  end

endmodule

[sim.f]
sv/y4m_pkg.sv
sv/y4m_chroma.sv
sv/y4m_div.sv
sv/y4m_header_line_parser_unit.sv
sv/y4m_checker.sv
test/y4m_checker.sv
test/tb_top.sv
